// File: rtl/core/srrc_pkg.sv
// Package holding the shared constants, codes and word types of the sequenced replay ring cache.
package srrc_pkg;

    localparam int CAPACITY_DEFAULT     = 16;
    localparam int PAYLOAD_BITS_DEFAULT = 32;
    localparam int MAX_RESULTS          = 16;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_COPY  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [2:0] STATUS_OK    = 3'd0;
    localparam logic [2:0] STATUS_STALE = 3'd1;
    localparam logic [2:0] STATUS_OLD   = 3'd2;
    localparam logic [2:0] STATUS_OVER  = 3'd3;
    localparam logic [2:0] STATUS_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] generation;
        logic [31:0] event_sequence;
        logic [31:0] event_payload;
        logic [31:0] resume_after;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] window_generation;
        logic [31:0] window_first;
        logic [31:0] window_last;
        logic [31:0] drop_total;
        logic        has_event;
        logic [31:0] out_sequence;
        logic [31:0] out_payload;
        logic        last_of_run;
    } result_t;

endpackage

// File: rtl/core/srrc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module srrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sequenced_replay_ring_cache.sv
// Top level of the sequenced replay ring cache: command decoding, ring control and result output.
//
// A command word is taken on cmd at a rising edge where start is high and busy
// is low. Each result word appears on result for exactly one cycle, marked by
// result_valid; the receiver takes it at the end of that cycle and cannot stall.
// A push, a clear, and any query or copy refused for its generation or for an
// empty ring give their single result in the cycle after acceptance, with busy
// staying low, so such commands can be issued every cycle.
// A query reads the first and last cached sequences from the sequence memory one
// after the other, in states ST_QFIRST and ST_QLAST, and gives its result after
// them; busy is high while it is in those states.
// A copy walks the ring one entry per cycle through the memory read port,
// oldest first, and delivers at most one event word per cycle; it holds busy while
// it visits the cached entries, at most CAPACITY of them, and in a final flush state,
// and the last word carries last_of_run.
// Reset empties the ring and clears the generation and the drop count. The
// memories are not cleared: only entries written since the last emptying are
// ever read.
module sequenced_replay_ring_cache #(
    parameter int CAPACITY     = srrc_pkg::CAPACITY_DEFAULT,
    parameter int PAYLOAD_BITS = srrc_pkg::PAYLOAD_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  srrc_pkg::cmd_t    cmd,
    output logic              result_valid,
    output srrc_pkg::result_t result
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int CAP_RESULTS = (CAPACITY < srrc_pkg::MAX_RESULTS) ?
                                 CAPACITY : srrc_pkg::MAX_RESULTS;
    localparam int CNT_W  = $clog2(CAP_RESULTS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_QFIRST = 3'd1;
    localparam logic [2:0] ST_QLAST  = 3'd2;
    localparam logic [2:0] ST_COPY   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       latest_reg, latest_next;
    logic [31:0]       gen_reg, gen_next;
    logic [31:0]       drops_reg, drops_next;
    logic [31:0]       after_reg, after_next;
    logic [31:0]       first_reg, first_next;
    logic [FILL_W-1:0] off_reg, off_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [31:0]       pend_seq_reg, pend_seq_next;
    logic [31:0]       pend_pay_reg, pend_pay_next;
    logic              result_valid_reg, result_valid_next;
    srrc_pkg::result_t result_reg, result_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic [31:0]             rd_seq;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [63:0]             wr_pay_wide;
    logic [63:0]             rd_pay_wide;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic srrc_pkg::result_t plain_result(input logic [2:0] status);
        srrc_pkg::result_t r;
        r = '0;
        r.status      = status;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    assign wr_pay_wide = 64'(cmd.event_payload);
    assign wr_pay      = wr_pay_wide[PAYLOAD_BITS-1:0];
    assign rd_pay_wide = 64'(rd_pay);

    srrc_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_seq_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.event_sequence),
        .rd_addr (rd_addr),
        .rd_data (rd_seq)
    );

    srrc_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_pay),
        .rd_addr (rd_addr),
        .rd_data (rd_pay)
    );

    always_comb
    begin
        logic [IDX_W-1:0]  eff_oldest;
        logic [FILL_W-1:0] eff_fill;
        logic [31:0]       eff_latest;
        logic              gap_drop;
        logic              over_drop;
        logic [33:0]       drop_sum;
        logic              hit;
        logic              finish;
        logic [31:0]       after_inc;

        state_next        = state_reg;
        oldest_next       = oldest_reg;
        fill_next         = fill_reg;
        latest_next       = latest_reg;
        gen_next          = gen_reg;
        drops_next        = drops_reg;
        after_next        = after_reg;
        first_next        = first_reg;
        off_next          = off_reg;
        cnt_next          = cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_seq_next     = pend_seq_reg;
        pend_pay_next     = pend_pay_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = oldest_reg;
        rd_addr           = oldest_reg;
        eff_oldest        = oldest_reg;
        eff_fill          = fill_reg;
        eff_latest        = latest_reg;
        gap_drop          = 1'b0;
        over_drop         = 1'b0;
        drop_sum          = '0;
        hit               = 1'b0;
        finish            = 1'b0;
        after_inc         = after_reg + 32'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_valid_next = 1'b1;
                    after_next        = cmd.resume_after;
                    if (cmd.func == srrc_pkg::FUNC_PUSH)
                    begin
                        if (cmd.generation == 32'd0 || cmd.event_sequence == 32'd0)
                        begin
                            result_next = plain_result(srrc_pkg::STATUS_STALE);
                        end
                        else
                        begin
                            if (cmd.generation != gen_reg)
                            begin
                                eff_oldest = '0;
                                eff_fill   = '0;
                                eff_latest = '0;
                            end
                            gen_next    = cmd.generation;
                            oldest_next = eff_oldest;
                            fill_next   = eff_fill;
                            latest_next = eff_latest;
                            if (eff_latest != 32'd0 && cmd.event_sequence <= eff_latest)
                            begin
                                result_next = plain_result(srrc_pkg::STATUS_OLD);
                            end
                            else
                            begin
                                gap_drop    = (eff_latest != 32'd0) &&
                                              (cmd.event_sequence != eff_latest + 32'd1);
                                latest_next = cmd.event_sequence;
                                wr_en       = 1'b1;
                                if (eff_fill == FILL_W'(CAPACITY))
                                begin
                                    over_drop   = 1'b1;
                                    wr_addr     = eff_oldest;
                                    oldest_next = slot_of(eff_oldest, FILL_W'(1));
                                    result_next = plain_result(srrc_pkg::STATUS_OVER);
                                end
                                else
                                begin
                                    wr_addr     = slot_of(eff_oldest, eff_fill);
                                    fill_next   = eff_fill + FILL_W'(1);
                                    result_next = plain_result(srrc_pkg::STATUS_OK);
                                end
                                drop_sum = 34'(drops_reg) + 34'(gap_drop) + 34'(over_drop);
                                if (drop_sum > 34'(32'hFFFF_FFFF))
                                begin
                                    drops_next = 32'hFFFF_FFFF;
                                end
                                else
                                begin
                                    drops_next = drop_sum[31:0];
                                end
                            end
                        end
                    end
                    else if (cmd.func == srrc_pkg::FUNC_CLEAR)
                    begin
                        oldest_next = '0;
                        fill_next   = '0;
                        latest_next = '0;
                        result_next = plain_result(srrc_pkg::STATUS_OK);
                    end
                    else if (cmd.generation == 32'd0 || cmd.generation != gen_reg)
                    begin
                        result_next = plain_result(srrc_pkg::STATUS_STALE);
                    end
                    else if (fill_reg == '0)
                    begin
                        result_next = plain_result(srrc_pkg::STATUS_EMPTY);
                    end
                    else
                    begin
                        result_valid_next = 1'b0;
                        rd_addr           = oldest_reg;
                        off_next          = '0;
                        cnt_next          = '0;
                        pend_valid_next   = 1'b0;
                        if (cmd.func == srrc_pkg::FUNC_QUERY)
                        begin
                            state_next = ST_QFIRST;
                        end
                        else
                        begin
                            state_next = ST_COPY;
                        end
                    end
                end
            end

            ST_QFIRST:
            begin
                first_next = rd_seq;
                rd_addr    = slot_of(oldest_reg, fill_reg - FILL_W'(1));
                state_next = ST_QLAST;
            end

            ST_QLAST:
            begin
                result_valid_next = 1'b1;
                if (after_inc < first_reg)
                begin
                    result_next = plain_result(srrc_pkg::STATUS_OVER);
                end
                else if (after_reg >= rd_seq)
                begin
                    result_next = plain_result(srrc_pkg::STATUS_EMPTY);
                end
                else
                begin
                    result_next = plain_result(srrc_pkg::STATUS_OK);
                end
                result_next.window_generation = gen_reg;
                result_next.window_first      = first_reg;
                result_next.window_last       = rd_seq;
                result_next.drop_total        = drops_reg;
                state_next = ST_IDLE;
            end

            ST_COPY:
            begin
                hit      = rd_seq > after_reg;
                off_next = off_reg + FILL_W'(1);
                rd_addr  = slot_of(oldest_reg, off_reg + FILL_W'(1));
                finish   = (off_reg + FILL_W'(1) == fill_reg) ||
                           (hit && (cnt_reg + CNT_W'(1) == CNT_W'(CAP_RESULTS)));
                if (hit)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next       = 1'b1;
                        result_next             = plain_result(srrc_pkg::STATUS_OK);
                        result_next.has_event    = 1'b1;
                        result_next.out_sequence = pend_seq_reg;
                        result_next.out_payload  = pend_pay_reg;
                        result_next.last_of_run  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_seq_next   = rd_seq;
                    pend_pay_next   = rd_pay_wide[31:0];
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
                if (finish)
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                result_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next              = plain_result(srrc_pkg::STATUS_OK);
                    result_next.has_event    = 1'b1;
                    result_next.out_sequence = pend_seq_reg;
                    result_next.out_payload  = pend_pay_reg;
                end
                else
                begin
                    result_next = plain_result(srrc_pkg::STATUS_EMPTY);
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            oldest_reg       <= '0;
            fill_reg         <= '0;
            latest_reg       <= '0;
            gen_reg          <= '0;
            drops_reg        <= '0;
            off_reg          <= '0;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            oldest_reg       <= oldest_next;
            fill_reg         <= fill_next;
            latest_reg       <= latest_next;
            gen_reg          <= gen_next;
            drops_reg        <= drops_next;
            off_reg          <= off_next;
            cnt_reg          <= cnt_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        after_reg    <= after_next;
        first_reg    <= first_next;
        pend_seq_reg <= pend_seq_next;
        pend_pay_reg <= pend_pay_next;
        result_reg   <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
